/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk_sig, rst_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk_sig, rst_sig, expr) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk_sig, rst_sig, prop)
`define ASSERT_NEVER(lbl, clk_sig, rst_sig, expr)
`endif
`endif

/* rtl/core/utf16d_pkg.sv */
// Types and constants of the UTF-16 decoder.
package utf16d_pkg;

  localparam logic [20:0] SubRepair = 21'h00FFFD;
  localparam logic [20:0] SubLegacy = 21'h00003F;
  localparam logic [20:0] SuppBase  = 21'h010000;
  localparam logic [5:0]  LeadTag   = 6'b110110;
  localparam logic [5:0]  TrailTag  = 6'b110111;

  typedef struct packed {
    logic        text_done;
    logic        item_done;
    logic        substituted;
    logic [20:0] code_point;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
    logic       lead_pending;
    logic [9:0] lead_bits;
  } step_out_t;

endpackage

/* rtl/core/utf16_decoder_repair.sv */
// UTF-16 to code point decoder, top level.
// An accepted word's first result, if it has one, is registered and shown on the output in the cycle after.
// One word per cycle while the output takes results; a word giving two results holds input until one is taken.
// The two-entry result queue and output back-pressure are the only limits on rate.
// Synchronous reset clears queue, pending lead and error_policy (repair mode).
`include "assert_macros.svh"
module utf16_decoder_repair (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,       // error_policy
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // unit
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // code_point[20:0], zero pad
  output logic [1:0]  m_axis_tuser,   // item_done, substituted
  output logic        m_axis_tlast    // text_done
);

  logic                  error_policy;
  logic                  lead_pending;
  logic [9:0]            lead_bits;
  logic [1:0]            count;
  logic [1:0]            count_next;
  utf16d_pkg::result_t   q0;
  utf16d_pkg::result_t   q1;
  utf16d_pkg::result_t   q0_next;
  utf16d_pkg::result_t   q1_next;
  utf16d_pkg::step_out_t step;
  logic                  pop;
  logic                  push;

  utf16d_step u_step (
    .policy       (error_policy),
    .lead_pending (lead_pending),
    .lead_bits    (lead_bits),
    .unit         (s_axis_tdata),
    .end_of_text  (s_axis_tlast),
    .step         (step)
  );

  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = (count != 2'd0);
  assign s_axis_tready = (count == 2'd0) || ((count == 2'd1) && m_axis_tready);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign push          = s_axis_tvalid && s_axis_tready;

  assign m_axis_tdata  = {3'd0, q0.code_point};
  assign m_axis_tuser  = {q0.item_done, q0.substituted};
  assign m_axis_tlast  = q0.text_done;

  // queue is empty after any pop when a word is taken
  always_comb begin
    q0_next    = q0;
    q1_next    = q1;
    count_next = count - {1'b0, pop};
    if (pop) begin
      q0_next = q1;
    end
    if (push) begin
      q0_next    = step.r0;
      q1_next    = step.r1;
      count_next = step.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_policy <= 1'b0;
      lead_pending <= 1'b0;
      count        <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        error_policy <= cfg_data;
      end
      if (push) begin
        lead_pending <= step.lead_pending;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && step.lead_pending) begin
      lead_bits <= step.lead_bits;
    end
    q0 <= q0_next;
    q1 <= q1_next;
  end

  `ASSERT_HOLDS(a_room_for_two, clk, rst, s_axis_tready |-> (count != 2'd2))
  `ASSERT_HOLDS(a_word_leaves_trace, clk, rst,
                (s_axis_tvalid && s_axis_tready) |=> (count != 2'd0 || lead_pending))
  `ASSERT_HOLDS(a_text_end_clears, clk, rst,
                (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !lead_pending)
  `ASSERT_NEVER(a_text_done_last, clk, rst, m_axis_tvalid && m_axis_tlast && !m_axis_tuser[1])

endmodule

/* rtl/core/utf16d_step.sv */
// Per-word decode: surrogate pairing, substitution and result framing.
module utf16d_step (
  input  logic                   policy,
  input  logic                   lead_pending,
  input  logic [9:0]             lead_bits,
  input  logic [15:0]            unit,
  input  logic                   end_of_text,
  output utf16d_pkg::step_out_t  step
);

  logic                is_lead;
  logic                is_trail;
  logic [20:0]         sub_cp;
  logic                fresh_n;
  logic                fresh_hold;
  utf16d_pkg::result_t fresh;
  utf16d_pkg::result_t r0;
  utf16d_pkg::result_t r1;
  logic [1:0]          n;

  assign is_lead  = (unit[15:10] == utf16d_pkg::LeadTag);
  assign is_trail = (unit[15:10] == utf16d_pkg::TrailTag);
  assign sub_cp   = policy ? utf16d_pkg::SubLegacy : utf16d_pkg::SubRepair;

  // word handled with no lead waiting
  always_comb begin
    fresh            = '0;
    fresh_n          = 1'b1;
    fresh_hold       = 1'b0;
    if (is_lead) begin
      fresh.code_point  = sub_cp;
      fresh.substituted = 1'b1;
      fresh_n           = end_of_text;
      fresh_hold        = !end_of_text;
    end else if (is_trail) begin
      fresh.code_point  = sub_cp;
      fresh.substituted = 1'b1;
    end else begin
      fresh.code_point  = {5'd0, unit};
    end
  end

  always_comb begin
    r0 = '0;
    r1 = '0;
    n  = 2'd0;
    step.lead_pending = 1'b0;
    step.lead_bits    = lead_bits;
    if (lead_pending) begin
      if (is_trail) begin
        r0.code_point = {1'b0, lead_bits, unit[9:0]} + utf16d_pkg::SuppBase;
        n             = 2'd1;
      end else if (policy) begin
        r0.code_point  = utf16d_pkg::SubLegacy;
        r0.substituted = 1'b1;
        n              = 2'd1;
      end else begin
        r0.code_point  = utf16d_pkg::SubRepair;
        r0.substituted = 1'b1;
        r1             = fresh;
        n              = 2'd1 + {1'b0, fresh_n};
        step.lead_pending = fresh_hold;
        step.lead_bits    = unit[9:0];
      end
    end else begin
      r0 = fresh;
      n  = {1'b0, fresh_n};
      step.lead_pending = fresh_hold;
      step.lead_bits    = unit[9:0];
    end
    if (n == 2'd2) begin
      r1.item_done = 1'b1;
      r1.text_done = end_of_text;
    end else begin
      r0.item_done = 1'b1;
      r0.text_done = end_of_text;
    end
    step.count = n;
    step.r0    = r0;
    step.r1    = r1;
  end

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the UTF-16 decoder with error repair.
module tb_top;

  localparam int QuietLimit = 500;
  localparam int PhaseWords = 300;

  typedef struct packed {
    logic        eot;
    logic [15:0] unit;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  word_t                word_q[$];
  utf16d_pkg::result_t  cp_expect[$];
  int          words_queued = 0;
  int          words_sent = 0;
  int          words_in = 0;
  int          results_out = 0;
  int          results_seen = 0;
  int          cfg_count = 0;
  int          errors = 0;
  int          quiet = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  bit          tx_idle = 1'b0;
  bit          rx_idle = 1'b0;
  bit          policy = 1'b0;
  bit          lead_held = 1'b0;
  logic [9:0]  lead_lo = '0;

  utf16_decoder_repair dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // Expected code points for one accepted word, using the current policy
  function automatic void decode_unit(logic [15:0] u, logic eot);
    logic [20:0]         cp[2];
    logic                sb[2];
    logic [9:0]          lb;
    bit                  had_lead;
    int                  n;
    utf16d_pkg::result_t r;
    n = 0;
    had_lead = lead_held;
    lb = lead_lo;
    lead_held = 1'b0;
    lead_lo = '0;
    if (had_lead) begin
      if (u[15:10] == utf16d_pkg::TrailTag) begin
        cp[0] = {1'b0, lb, u[9:0]} + utf16d_pkg::SuppBase;
        sb[0] = 1'b0;
      end else begin
        cp[0] = policy ? utf16d_pkg::SubLegacy : utf16d_pkg::SubRepair;
        sb[0] = 1'b1;
      end
      n = 1;
    end
    if (!had_lead || (!policy && u[15:10] != utf16d_pkg::TrailTag)) begin
      if (u[15:10] == utf16d_pkg::LeadTag && !eot) begin
        lead_held = 1'b1;
        lead_lo = u[9:0];
      end else if (u[15:10] == utf16d_pkg::LeadTag || u[15:10] == utf16d_pkg::TrailTag) begin
        cp[n] = policy ? utf16d_pkg::SubLegacy : utf16d_pkg::SubRepair;
        sb[n] = 1'b1;
        n++;
      end else begin
        cp[n] = {5'b0, u};
        sb[n] = 1'b0;
        n++;
      end
    end
    if (eot) begin
      lead_held = 1'b0;
      lead_lo = '0;
    end
    for (int k = 0; k < n; k++) begin
      r.code_point  = cp[k];
      r.substituted = sb[k];
      r.item_done   = (k == n - 1);
      r.text_done   = eot && (k == n - 1);
      cp_expect.push_back(r);
    end
  endfunction

  task automatic check_field(string what, logic [20:0] exp_v, logic [20:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, exp_v, act_v);
    end
  endtask

  // Handshake monitor, predictor and watchdog
  always @(posedge clk) begin
    utf16d_pkg::result_t want;
    if (rst) begin
      quiet = 0;
    end else begin
      quiet++;
      if (cfg_valid && cfg_ready) begin
        policy = cfg_data;
        cfg_count++;
        quiet = 0;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decode_unit(s_axis_tdata, s_axis_tlast);
        words_in++;
        quiet = 0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_out++;
        quiet = 0;
        if (cp_expect.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: expected none, actual cp %0h", $time,
                   m_axis_tdata[20:0]);
        end else begin
          want = cp_expect.pop_front();
          check_field("code_point", want.code_point, m_axis_tdata[20:0]);
          check_field("substituted", 21'(want.substituted), 21'(m_axis_tuser[0]));
          check_field("item_done", 21'(want.item_done), 21'(m_axis_tuser[1]));
          check_field("text_done", 21'(want.text_done), 21'(m_axis_tlast));
        end
      end
      if (quiet >= QuietLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Input driver
  always @(negedge clk) begin
    word_t w;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (words_sent == words_in) begin
      if (in_gap > 0 || word_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (in_gap > 0) in_gap--;
      end else begin
        w = word_q.pop_front();
        s_axis_tdata  <= w.unit;
        s_axis_tlast  <= w.eot;
        s_axis_tvalid <= 1'b1;
        words_sent++;
        in_gap = tx_idle ? $urandom_range(0, 16) : 0;
      end
    end
  end

  // Output back-pressure
  always @(negedge clk) begin
    if (results_seen != results_out) begin
      results_seen = results_out;
      out_gap = rx_idle ? $urandom_range(0, 16) : 0;
    end
    if (out_gap > 0) begin
      m_axis_tready <= 1'b0;
      out_gap--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic void push_word(logic [15:0] u, logic e);
    word_q.push_back('{eot: e, unit: u});
    words_queued++;
  endfunction

  // any unit outside the surrogate block
  function automatic logic [15:0] bmp_unit();
    logic [15:0] u;
    u = 16'($urandom_range(0, 16'hF7FF));
    if (u >= 16'hD800) u = u + 16'h0800;
    return u;
  endfunction

  function automatic logic [15:0] lead_unit();
    return {utf16d_pkg::LeadTag, 10'($urandom)};
  endfunction

  function automatic logic [15:0] trail_unit();
    return {utf16d_pkg::TrailTag, 10'($urandom)};
  endfunction

  function automatic void push_text();
    int len;
    bit last;
    len = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      last = (i == len - 1);
      if ($urandom_range(0, 2) == 0) begin
        push_word(lead_unit(), 1'b0);
        push_word(trail_unit(), last);
      end else begin
        push_word(bmp_unit(), last);
      end
    end
  endfunction

  function automatic void push_broken();
    bit e;
    e = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 5))
      0: push_word(trail_unit(), e);
      1: begin
        push_word(lead_unit(), 1'b0);
        push_word(bmp_unit(), e);
      end
      2: begin
        push_word(lead_unit(), 1'b0);
        push_word(lead_unit(), e);
      end
      3: push_word(lead_unit(), 1'b1);
      4: push_word(16'($urandom), e);
      default: begin
        push_word(lead_unit(), 1'b0);
        push_word(16'($urandom), e);
      end
    endcase
  endfunction

  // wait until every word is taken and every result checked
  task automatic settle();
    while (word_q.size() != 0 || words_sent != words_in || cp_expect.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_policy(bit v);
    int n;
    n = cfg_count;
    @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (cfg_count == n);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int target;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // repair mode from reset
    push_word(16'h0000, 1'b0);
    push_word(16'hFFFF, 1'b0);
    push_word(16'hD7FF, 1'b0);
    push_word(16'hE000, 1'b0);
    push_word(16'hD800, 1'b0);
    push_word(16'hDC00, 1'b0);
    push_word(16'hDBFF, 1'b0);
    push_word(16'hDFFF, 1'b0);
    push_word(16'hDC00, 1'b0);
    push_word(16'hDFFF, 1'b0);
    push_word(16'hD800, 1'b0);
    push_word(16'h0041, 1'b0);
    push_word(16'hDA00, 1'b0);
    push_word(16'hDB00, 1'b0);
    push_word(16'hDE00, 1'b0);
    push_word(16'hD900, 1'b1);
    push_word(16'hD801, 1'b0);
    push_word(16'hD802, 1'b1);
    push_word(16'hD803, 1'b0);
    push_word(16'hDC05, 1'b1);
    push_word(16'hD8AB, 1'b0);
    settle();
    // policy changes while a lead waits
    set_policy(1'b1);
    push_word(16'h0000, 1'b0);
    push_word(16'hDBFF, 1'b0);
    push_word(16'hDBFF, 1'b0);
    push_word(16'hDC10, 1'b0);
    push_word(16'hD810, 1'b1);
    push_word(16'hD800, 1'b0);
    push_word(16'hDC00, 1'b0);
    push_word(16'hD805, 1'b0);
    push_word(16'h0041, 1'b1);
    push_word(16'hDBFE, 1'b0);
    settle();
    set_policy(1'b0);
    push_word(16'h0042, 1'b1);
    settle();

    for (int p = 0; p < 6; p++) begin
      set_policy(p % 2 == 0);
      tx_idle = (p % 3 != 0);
      rx_idle = (p % 2 == 0) || (p == 5);
      target = words_queued + PhaseWords;
      while (words_queued < target) begin
        if ($urandom_range(0, 4) == 0) push_broken();
        else push_text();
      end
      settle();
    end

    repeat (4) @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
